### hdl/jsu_pkg.sv
package jsu_pkg;

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Most results one input byte can cause
  localparam int unsigned MAX_RES = 4;
  localparam int unsigned RES_IDX_W = $clog2(MAX_RES);
  localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);

  // Characters with a meaning to the parser
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_U = 8'h75;

  // Bytes that the simple escapes stand for
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_BS = 8'h08;
  localparam logic [7:0] BYTE_FF = 8'h0C;

  // Hex digits in a \u escape
  localparam int unsigned HEX_DIGITS = 4;
  localparam logic [1:0] HEX_LAST = 2'(HEX_DIGITS - 1);

  // All results caused by one input byte, in order
  typedef struct packed {
    logic [RES_CNT_W-1:0]              cnt;
    logic [MAX_RES-1:0][7:0]           bytes;
    logic [MAX_RES-1:0][1:0]           kinds;
  } burst_t;

  // Hex digit decode: bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

### hdl/jsu_if.sv
// Input channel: one raw byte per transfer
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// Result channel: one result per transfer
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       out_last;

  modport source (output valid, output out_byte, output out_kind, output out_last,
                  input ready);
  modport sink (input valid, input out_byte, input out_kind, input out_last,
                output ready);
endinterface

### hdl/jsu_parser.sv
module jsu_parser
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] item_byte,
  input  logic       item_last,
  output burst_t     burst
);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STR  = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [15:0] acc_r, acc_nxt;

  logic [4:0]  hex;
  logic [15:0] cp;
  logic        ended;
  logic [RES_CNT_W-1:0] n;

  assign hex = hex_decode(item_byte);
  assign cp  = {acc_r[11:0], hex[3:0]};

  // Next state and the results of this byte
  always_comb begin
    mode_nxt    = mode_r;
    hex_cnt_nxt = hex_cnt_r;
    acc_nxt     = acc_r;
    ended       = 1'b0;
    n           = '0;
    burst.bytes = '0;
    burst.kinds = '0;
    case (mode_r)
      MODE_IDLE: begin
        if (item_byte != CH_QUOTE) begin
          burst.kinds[0] = KIND_ERROR;
          n     = RES_CNT_W'(1);
          ended = 1'b1;
        end else begin
          mode_nxt = MODE_STR;
        end
      end
      MODE_STR: begin
        if (item_byte == CH_QUOTE) begin
          burst.kinds[0] = KIND_DONE;
          n        = RES_CNT_W'(1);
          ended    = 1'b1;
          mode_nxt = MODE_IDLE;
        end else if (item_byte == CH_BSLASH) begin
          mode_nxt = MODE_ESC;
        end else if (item_byte[7:5] == 3'd0) begin
          // control byte inside the string
          burst.kinds[0] = KIND_ERROR;
          n        = RES_CNT_W'(1);
          ended    = 1'b1;
          mode_nxt = MODE_IDLE;
        end else begin
          burst.bytes[0] = item_byte;
          burst.kinds[0] = KIND_DATA;
          n = RES_CNT_W'(1);
        end
      end
      MODE_ESC: begin
        n        = RES_CNT_W'(1);
        mode_nxt = MODE_STR;
        burst.kinds[0] = KIND_DATA;
        case (item_byte)
          CH_QUOTE:  burst.bytes[0] = CH_QUOTE;
          CH_BSLASH: burst.bytes[0] = CH_BSLASH;
          CH_SLASH:  burst.bytes[0] = CH_SLASH;
          CH_N:      burst.bytes[0] = BYTE_LF;
          CH_R:      burst.bytes[0] = BYTE_CR;
          CH_T:      burst.bytes[0] = BYTE_TAB;
          CH_B:      burst.bytes[0] = BYTE_BS;
          CH_F:      burst.bytes[0] = BYTE_FF;
          CH_U: begin
            n           = '0;
            mode_nxt    = MODE_HEX;
            hex_cnt_nxt = '0;
            acc_nxt     = '0;
          end
          default: begin
            burst.kinds[0] = KIND_ERROR;
            ended    = 1'b1;
            mode_nxt = MODE_IDLE;
          end
        endcase
      end
      MODE_HEX: begin
        if (!hex[4]) begin
          burst.kinds[0] = KIND_ERROR;
          n        = RES_CNT_W'(1);
          ended    = 1'b1;
          mode_nxt = MODE_IDLE;
          hex_cnt_nxt = '0;
          acc_nxt     = '0;
        end else if (hex_cnt_r == HEX_LAST) begin
          // last digit: encode the code point as UTF-8
          if (cp < 16'h0080) begin
            burst.bytes[0] = cp[7:0];
            n = RES_CNT_W'(1);
          end else if (cp < 16'h0800) begin
            burst.bytes[0] = {3'b110, cp[10:6]};
            burst.bytes[1] = {2'b10, cp[5:0]};
            n = RES_CNT_W'(2);
          end else begin
            burst.bytes[0] = {4'b1110, cp[15:12]};
            burst.bytes[1] = {2'b10, cp[11:6]};
            burst.bytes[2] = {2'b10, cp[5:0]};
            n = RES_CNT_W'(3);
          end
          mode_nxt    = MODE_STR;
          hex_cnt_nxt = '0;
          acc_nxt     = '0;
        end else begin
          acc_nxt     = cp;
          hex_cnt_nxt = hex_cnt_r + 2'd1;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase

    // input ran out before the string closed
    if (item_last && !ended) begin
      burst.kinds[n[RES_IDX_W-1:0]] = KIND_ERROR;
      burst.bytes[n[RES_IDX_W-1:0]] = '0;
      n           = n + RES_CNT_W'(1);
      mode_nxt    = MODE_IDLE;
      hex_cnt_nxt = '0;
      acc_nxt     = '0;
    end
    burst.cnt = n;
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      hex_cnt_r <= '0;
      acc_r     <= '0;
    end else if (take) begin
      mode_r    <= mode_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      acc_r     <= acc_nxt;
    end
  end

endmodule

### hdl/jsu_emitter.sv
module jsu_emitter
  import jsu_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  burst_t       burst,
  output logic         can_load,
  jsu_out_if.source    out_ch
);

  logic                       valid_r;
  logic [RES_CNT_W-1:0]       cnt_r;
  logic [RES_IDX_W-1:0]       idx_r;
  logic [MAX_RES-1:0][7:0]    bytes_r;
  logic [MAX_RES-1:0][1:0]    kinds_r;

  logic final_res;
  logic xfer;
  logic fill;

  assign final_res = (RES_CNT_W'(idx_r) + RES_CNT_W'(1)) == cnt_r;
  assign xfer      = valid_r && out_ch.ready;
  assign can_load  = !valid_r || (xfer && final_res);
  assign fill      = load && can_load && (burst.cnt != '0);

  assign out_ch.valid    = valid_r;
  assign out_ch.out_byte = bytes_r[idx_r];
  assign out_ch.out_kind = kinds_r[idx_r];
  assign out_ch.out_last = final_res;

  // Control: hold a burst and step through it one transfer at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (fill) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (xfer) begin
      if (final_res) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + RES_IDX_W'(1);
      end
    end
  end

  // Burst payload
  always_ff @(posedge clk) begin
    if (fill) begin
      cnt_r   <= burst.cnt;
      bytes_r <= burst.bytes;
      kinds_r <= burst.kinds;
    end
  end

endmodule

### hdl/json_string_unescaper.sv
// Streaming JSON string unescaper. Takes one raw byte per transfer on in_ch and
// gives unescaped bytes on out_ch, then a done result at the closing quote or an
// error result, after which it waits for the next opening quote. A byte flagged
// in_last that leaves the string open also gets an error. Each byte is parsed
// from an input register into a result buffer, so the block takes one byte
// per cycle while each byte causes at most one result and out_ch is ready. The
// result buffer drains one result per cycle while out_ch is ready; the last
// hex digit of a \u escape gives up to three results (with a final early-end
// error, four), and the parser takes the next byte only once the buffer is
// empty or hands over the last result of the byte before.
// The input register lets one byte be taken while a result waits on out_ch.
module json_string_unescaper
  import jsu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);

  logic       hold_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       can_load;
  logic       take;
  burst_t     burst;

  assign take        = hold_r && can_load;
  assign in_ch.ready = !hold_r || take;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else if (in_ch.ready) begin
      hold_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.in_byte;
      last_r <= in_ch.in_last;
    end
  end

  jsu_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .item_byte (byte_r),
    .item_last (last_r),
    .burst     (burst)
  );

  jsu_emitter u_emitter (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (take),
    .burst    (burst),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

### hdl/jsu_checker.sv
module jsu_checker
  import jsu_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] out_kind,
  input logic       out_last
);

  // Only the three defined kinds appear
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_DATA || out_kind == KIND_DONE ||
                   out_kind == KIND_ERROR))
    else $error("illegal result kind");

  // Done and error results carry a zero byte
  a_status_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_DATA) |-> out_byte == 8'd0)
    else $error("status result with nonzero byte");

  // A status result always closes the results of its byte
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_DATA) |-> out_last)
    else $error("status result not marked last");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_byte) && $stable(out_kind) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_kind  (out_ch.out_kind),
  .out_last  (out_ch.out_last)
);

### dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned IDLE_PCT = 31;

  // Parser position inside the quoted string
  typedef enum logic [1:0] {
    WAIT_OPEN = 2'd0,
    IN_STR    = 2'd1,
    AFTER_ESC = 2'd2,
    IN_HEX    = 2'd3
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } result_t;

  logic clk;
  logic rst_n;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescaper dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state
  scan_mode_t  scan_mode = WAIT_OPEN;
  logic [1:0]  digits_seen = '0;
  logic [15:0] code_acc = '0;

  result_t     pending_results[$];
  logic [8:0]  stim_q[$];       // {last, byte}
  int unsigned items_sent = 0;
  int unsigned failures = 0;
  int unsigned cycle_count = 0;
  bit          steady = 1'b0;   // no idling on either side while set
  result_t     want;
  result_t     got;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side backpressure
  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Hex digit value, bit 4 set for a legal digit
  function automatic logic [4:0] nibble_of(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return {1'b1, 4'(ch - "0")};
    if (ch >= "a" && ch <= "f") return {1'b1, 4'(ch - "a" + 8'd10)};
    if (ch >= "A" && ch <= "F") return {1'b1, 4'(ch - "A" + 8'd10)};
    return 5'd0;
  endfunction

  function automatic result_t mk_result(input logic [7:0] data, input logic [1:0] kind);
    result_t r;
    r.data = data;
    r.kind = kind;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void back_to_wait();
    scan_mode = WAIT_OPEN;
    digits_seen = '0;
    code_acc = '0;
  endfunction

  // Expected results of one accepted input byte
  function automatic void unescape_predict(input logic [7:0] ch, input logic lst);
    result_t    burst[$];
    logic       ended;
    logic       mapped_ok;
    logic [7:0] mapped;
    logic [4:0] nib;
    logic [15:0] cp;
    ended = 1'b0;
    mapped_ok = 1'b1;
    mapped = '0;
    case (scan_mode)
      WAIT_OPEN: begin
        if (ch != CH_QUOTE) begin
          burst.push_back(mk_result(8'h00, KIND_ERROR));
          ended = 1'b1;
        end else begin
          scan_mode = IN_STR;
        end
      end
      IN_STR: begin
        if (ch == CH_QUOTE) begin
          burst.push_back(mk_result(8'h00, KIND_DONE));
          back_to_wait();
          ended = 1'b1;
        end else if (ch == CH_BSLASH) begin
          scan_mode = AFTER_ESC;
        end else if (ch < 8'h20) begin
          burst.push_back(mk_result(8'h00, KIND_ERROR));
          back_to_wait();
          ended = 1'b1;
        end else begin
          burst.push_back(mk_result(ch, KIND_DATA));
        end
      end
      AFTER_ESC: begin
        case (ch)
          CH_QUOTE:  mapped = CH_QUOTE;
          CH_BSLASH: mapped = CH_BSLASH;
          CH_SLASH:  mapped = CH_SLASH;
          CH_N:      mapped = BYTE_LF;
          CH_R:      mapped = BYTE_CR;
          CH_T:      mapped = BYTE_TAB;
          CH_B:      mapped = BYTE_BS;
          CH_F:      mapped = BYTE_FF;
          default:   mapped_ok = 1'b0;
        endcase
        if (ch == CH_U) begin
          scan_mode = IN_HEX;
          digits_seen = '0;
          code_acc = '0;
        end else if (mapped_ok) begin
          burst.push_back(mk_result(mapped, KIND_DATA));
          scan_mode = IN_STR;
        end else begin
          burst.push_back(mk_result(8'h00, KIND_ERROR));
          back_to_wait();
          ended = 1'b1;
        end
      end
      default: begin
        nib = nibble_of(ch);
        if (!nib[4]) begin
          burst.push_back(mk_result(8'h00, KIND_ERROR));
          back_to_wait();
          ended = 1'b1;
        end else begin
          code_acc = {code_acc[11:0], nib[3:0]};
          if (digits_seen == HEX_LAST) begin
            cp = code_acc;
            // UTF-8 encoding, one to three bytes
            if (cp < 16'h0080) begin
              burst.push_back(mk_result(cp[7:0], KIND_DATA));
            end else if (cp < 16'h0800) begin
              burst.push_back(mk_result({3'b110, cp[10:6]}, KIND_DATA));
              burst.push_back(mk_result({2'b10, cp[5:0]}, KIND_DATA));
            end else begin
              burst.push_back(mk_result({4'b1110, cp[15:12]}, KIND_DATA));
              burst.push_back(mk_result({2'b10, cp[11:6]}, KIND_DATA));
              burst.push_back(mk_result({2'b10, cp[5:0]}, KIND_DATA));
            end
            scan_mode = IN_STR;
            digits_seen = '0;
            code_acc = '0;
          end else begin
            digits_seen = digits_seen + 2'd1;
          end
        end
      end
    endcase
    // Input ran out with the string still open
    if (lst && !ended) begin
      burst.push_back(mk_result(8'h00, KIND_ERROR));
      back_to_wait();
    end
    if (burst.size() != 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) pending_results.push_back(burst[i]);
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.data = out_ch.out_byte;
      got.kind = out_ch.out_kind;
      got.last = out_ch.out_last;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: byte=%h kind=%0d last=%0b",
                 $time, got.data, got.kind, got.last);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (got.data !== want.data || got.kind !== want.kind || got.last !== want.last) begin
          $display({"%0t: mismatch: expected byte=%h kind=%0d last=%0b, ",
                    "actual byte=%h kind=%0d last=%0b"},
                   $time, want.data, want.kind, want.last, got.data, got.kind, got.last);
          failures++;
        end
      end
    end
  end

  // One input transfer; called and left at a falling edge
  task automatic send_item(input logic [7:0] ch, input logic lst);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid   <= 1'b0;
      in_ch.in_byte <= 8'($urandom);
      in_ch.in_last <= 1'($urandom);
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= ch;
    in_ch.in_last <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    unescape_predict(ch, lst);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_queued();
    logic [8:0] entry;
    while (stim_q.size() != 0) begin
      entry = stim_q.pop_front();
      send_item(entry[7:0], entry[8]);
    end
  endtask

  function automatic void queue_byte(input logic [7:0] ch, input logic lst = 1'b0);
    stim_q.push_back({lst, ch});
  endfunction

  function automatic void queue_text(input string s);
    for (int i = 0; i < s.len(); i++) stim_q.push_back({1'b0, 8'(s[i])});
  endfunction

  function automatic void mark_last();
    stim_q[stim_q.size() - 1][8] = 1'b1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  // One string element: plain byte, simple escape or \u escape
  function automatic void queue_token();
    logic [7:0]  ch;
    logic [7:0]  esc_set[8];
    logic [15:0] cp;
    int unsigned pick;
    esc_set = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_N, CH_R, CH_T, CH_B, CH_F};
    pick = $urandom_range(9);
    if (pick < 5) begin
      do ch = 8'($urandom_range(8'h20, 8'hFF));
      while (ch == CH_QUOTE || ch == CH_BSLASH);
      queue_byte(ch);
    end else if (pick < 7) begin
      queue_byte(CH_BSLASH);
      queue_byte(esc_set[$urandom_range(7)]);
    end else begin
      case ($urandom_range(2))
        0:       cp = 16'($urandom_range(16'h0000, 16'h007F));
        1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
        default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
      endcase
      queue_byte(CH_BSLASH);
      queue_byte(CH_U);
      for (int i = 3; i >= 0; i--) queue_byte(hex_char(cp[i*4 +: 4], 1'($urandom)));
    end
  endfunction

  // Mostly well-formed strings, some noise and broken strings
  function automatic void queue_random_sequence();
    int unsigned pick;
    int unsigned n_tok;
    logic [7:0]  ch;
    logic [4:0]  nib;
    pick = $urandom_range(99);
    if (pick < 8) begin
      queue_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
      return;
    end
    queue_byte(CH_QUOTE);
    n_tok = $urandom_range(6);
    repeat (n_tok) queue_token();
    if (pick < 80) begin
      queue_byte(CH_QUOTE);
      if ($urandom_range(4) == 0) mark_last();
      return;
    end
    case ($urandom_range(3))
      0: queue_byte(8'($urandom_range(8'h1F)), $urandom_range(3) == 0);
      1: begin
        do ch = 8'($urandom_range(255));
        while (ch inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_N, CH_R, CH_T, CH_B, CH_F, CH_U});
        queue_byte(CH_BSLASH);
        queue_byte(ch, $urandom_range(3) == 0);
      end
      2: begin
        queue_byte(CH_BSLASH);
        queue_byte(CH_U);
        repeat ($urandom_range(3)) queue_byte(hex_char(4'($urandom), 1'($urandom)));
        do begin
          ch = 8'($urandom_range(255));
          nib = nibble_of(ch);
        end while (nib[4]);
        queue_byte(ch, $urandom_range(3) == 0);
      end
      default: mark_last();
    endcase
  endfunction

  // Wrong opening bytes, lowest and highest plain bytes, control byte
  task automatic test_open_and_control();
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(CH_QUOTE);
    queue_byte(8'h20);
    queue_byte(8'hFF);
    queue_byte(8'h1F);
    send_queued();
  endtask

  // Simple escape, then an escape letter outside the set
  task automatic test_escapes();
    queue_text("\"\\n\\q");
    send_queued();
  endtask

  // Three-byte code point, then a closing quote that is also the last byte
  task automatic test_unicode_widths();
    queue_text("\"\\uFFFF\"");
    mark_last();
    send_queued();
  endtask

  task automatic test_bad_hex();
    queue_text("\"\\u0g");
    send_queued();
  endtask

  // Two-byte code point plus early-end error from one byte, then a lone quote
  task automatic test_early_end();
    queue_text("\"\\u07fF");
    mark_last();
    queue_byte(CH_QUOTE, 1'b1);
    send_queued();
  endtask

  task automatic test_random_strings(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      queue_random_sequence();
      send_queued();
    end
  endtask

  // Random strings with the bench never idling on either side
  task automatic test_back_to_back(input int unsigned n_items);
    steady = 1'b1;
    test_random_strings(n_items);
    steady = 1'b0;
  endtask

  // Main sequence
  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = 8'h00;
    in_ch.in_last  = 1'b0;
    out_ch.ready   = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_open_and_control();
    test_escapes();
    test_unicode_widths();
    test_bad_hex();
    test_early_end();
    test_random_strings(110);
    test_back_to_back(70);
    test_random_strings(70);

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
